// ===== rtl/dlpg_pkg.sv =====
package dlpg_pkg;

    // field widths
    localparam int unsigned CoordWidth  = 13;
    localparam int unsigned ValueWidth  = 8;
    localparam int unsigned PixelWidth  = 5;
    localparam int unsigned PosWidth    = 24;
    localparam int unsigned StepWidth   = 18;
    localparam int unsigned QuoWidth    = 16;
    localparam int unsigned CountWidth  = 6;
    localparam int unsigned DivCntWidth = 4;

    // stream payload widths, padded to whole bytes
    localparam int unsigned InDataWidth  = 64;
    localparam int unsigned OutDataWidth = 24;

    // default image side in pixels
    localparam int unsigned ImageSideDefault = 32;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic div_step;
        logic set_step;
        logic emit;
    } t_dp_cmd;

    // status from the datapath to the controller
    typedef struct packed {
        logic emit_last;
    } t_dp_status;

endpackage

// ===== rtl/dlpg_ctrl.sv =====
module dlpg_ctrl
    import dlpg_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic       i_m_tready,
    output logic       o_m_tvalid,
    output t_dp_cmd    o_cmd,
    input  t_dp_status i_status
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_STEP,
        ST_EMIT
    } t_state;

    t_state                 r_state;
    t_state                 n_state;
    logic [DivCntWidth-1:0] r_div_cnt;
    logic [DivCntWidth-1:0] n_div_cnt;
    logic                   r_out_valid;
    logic                   n_out_valid;
    logic                   slot_free;
    logic                   accept;

    // output register can take a new pixel
    assign slot_free = !r_out_valid || i_m_tready;
    assign accept    = (r_state == ST_IDLE) && i_s_tvalid;

    assign o_s_tready = (r_state == ST_IDLE);
    assign o_m_tvalid = r_out_valid;

    // command decode
    always_comb begin
        o_cmd          = '0;
        o_cmd.load     = accept;
        o_cmd.div_step = (r_state == ST_DIV);
        o_cmd.set_step = (r_state == ST_STEP);
        o_cmd.emit     = (r_state == ST_EMIT) && slot_free;
    end

    // next state
    always_comb begin
        n_state     = r_state;
        n_div_cnt   = r_div_cnt;
        n_out_valid = r_out_valid;
        if (i_m_tready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            ST_IDLE: begin
                if (i_s_tvalid) begin
                    n_state   = ST_DIV;
                    n_div_cnt = '0;
                end
            end
            ST_DIV: begin
                n_div_cnt = r_div_cnt + 1'b1;
                if (r_div_cnt == {DivCntWidth{1'b1}}) begin
                    n_state = ST_STEP;
                end
            end
            ST_STEP: begin
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    if (i_status.emit_last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_div_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_div_cnt   <= n_div_cnt;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// ===== rtl/dlpg_dp.sv =====
module dlpg_dp
    import dlpg_pkg::*;
#(
    parameter int unsigned IMAGE_SIDE = ImageSideDefault
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_dp_cmd               i_cmd,
    output t_dp_status            o_status,
    input  logic [CoordWidth-1:0] i_start_x,
    input  logic [CoordWidth-1:0] i_start_y,
    input  logic [CoordWidth-1:0] i_end_x,
    input  logic [CoordWidth-1:0] i_end_y,
    input  logic [ValueWidth-1:0] i_paint_value,
    output logic [PixelWidth-1:0] o_pixel_x,
    output logic [PixelWidth-1:0] o_pixel_y,
    output logic [ValueWidth-1:0] o_pixel_value,
    output logic                  o_last
);

    localparam logic [7:0] SideMax = 8'(IMAGE_SIDE - 1);
    localparam logic signed [StepWidth-1:0] StepOne = StepWidth'(65536);

    // request and line set-up
    logic [PixelWidth-1:0]       r_end_x;
    logic [PixelWidth-1:0]       r_end_y;
    logic [ValueWidth-1:0]       r_value;
    logic                        r_neg_x;
    logic                        r_neg_y;
    logic                        r_vertical;
    logic                        r_y_major;
    logic                        r_tie;
    logic [CountWidth-1:0]       r_remaining;
    logic                        r_end_pending;
    logic signed [PosWidth-1:0]  r_cur_x;
    logic signed [PosWidth-1:0]  r_cur_y;
    logic signed [StepWidth-1:0] r_step_x;
    logic signed [StepWidth-1:0] r_step_y;

    // divider
    logic [CoordWidth:0]         r_div_rem;
    logic [CoordWidth-1:0]       r_divisor;
    logic [QuoWidth-1:0]         r_quo;

    // output register
    logic [PixelWidth-1:0]       r_out_x;
    logic [PixelWidth-1:0]       r_out_y;
    logic [ValueWidth-1:0]       r_out_value;
    logic                        r_out_last;

    logic [CoordWidth-1:0]       adx;
    logic [CoordWidth-1:0]       ady;
    logic                        neg_x;
    logic                        neg_y;
    logic                        vertical;
    logic                        y_major;
    logic [CoordWidth-1:0]       major;
    logic [CoordWidth-1:0]       minor;
    logic [CountWidth-1:0]       length;
    logic [CoordWidth+1:0]       rem_shift;
    logic [CoordWidth+1:0]       rem_diff;
    logic                        rem_ge;
    logic signed [StepWidth-1:0] minor_mag;
    logic signed [StepWidth-1:0] minor_step;
    logic                        emit_last;

    // floor of a q.16 position, saturated to the image
    function automatic logic [PixelWidth-1:0] clamp_pos(
        input logic signed [PosWidth-1:0] pos
    );
        logic [7:0] p;
        begin
            p = pos[PosWidth-1:16];
            if (pos[PosWidth-1]) begin
                p = '0;
            end else if (p > SideMax) begin
                p = SideMax;
            end
            clamp_pos = p[PixelWidth-1:0];
        end
    endfunction

    // end pixel, already non-negative
    function automatic logic [PixelWidth-1:0] clamp_pix(
        input logic [PixelWidth-1:0] pix
    );
        logic [7:0] p;
        begin
            p = {3'b000, pix};
            if (p > SideMax) begin
                p = SideMax;
            end
            clamp_pix = p[PixelWidth-1:0];
        end
    endfunction

    // deltas, magnitudes and axis choice
    always_comb begin
        neg_x    = i_end_x < i_start_x;
        neg_y    = i_end_y < i_start_y;
        adx      = neg_x ? (i_start_x - i_end_x) : (i_end_x - i_start_x);
        ady      = neg_y ? (i_start_y - i_end_y) : (i_end_y - i_start_y);
        vertical = (i_end_x == i_start_x);
        y_major  = ady > adx;
        major    = y_major ? ady : adx;
        minor    = y_major ? adx : ady;
        if (vertical) begin
            length = {1'b0, ady[CoordWidth-1:8]};
        end else begin
            length = {1'b0, major[CoordWidth-1:8]} + 1'b1;
        end
    end

    // one restoring division step
    always_comb begin
        rem_shift = {r_div_rem, 1'b0};
        rem_diff  = rem_shift - {2'b00, r_divisor};
        rem_ge    = !rem_diff[CoordWidth+1];
    end

    // minor axis step from the quotient
    always_comb begin
        minor_mag  = r_tie ? StepOne : {2'b00, r_quo};
        minor_step = (r_y_major ? r_neg_x : r_neg_y) ? -minor_mag : minor_mag;
    end

    // this pixel closes the line
    assign emit_last = r_end_pending ? (r_remaining == '0)
                                     : (r_remaining == CountWidth'(1));
    assign o_status.emit_last = emit_last;

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_end_x    <= i_end_x[CoordWidth-1:8];
            r_end_y    <= i_end_y[CoordWidth-1:8];
            r_value    <= i_paint_value;
            r_neg_x    <= neg_x;
            r_neg_y    <= neg_y;
            r_vertical <= vertical;
            r_y_major  <= y_major && !vertical;
            r_tie      <= (adx == ady);
            r_cur_x    <= {3'b000, i_start_x, 8'h00};
            r_cur_y    <= {3'b000, i_start_y, 8'h00};
            r_div_rem  <= {1'b0, minor};
            r_divisor  <= major;
            r_quo      <= '0;
        end
        if (i_cmd.div_step) begin
            r_div_rem <= rem_ge ? rem_diff[CoordWidth:0] : rem_shift[CoordWidth:0];
            r_quo     <= {r_quo[QuoWidth-2:0], rem_ge};
        end
        if (i_cmd.set_step) begin
            if (r_vertical) begin
                r_step_x <= '0;
                r_step_y <= r_neg_y ? -StepOne : StepOne;
            end else if (r_y_major) begin
                r_step_x <= minor_step;
                r_step_y <= r_neg_y ? -StepOne : StepOne;
            end else begin
                r_step_x <= r_neg_x ? -StepOne : StepOne;
                r_step_y <= minor_step;
            end
        end
        if (i_cmd.emit) begin
            r_out_value <= r_value;
            r_out_last  <= emit_last;
            if (r_end_pending) begin
                r_out_x <= clamp_pix(r_end_x);
                r_out_y <= clamp_pix(r_end_y);
            end else begin
                r_out_x <= clamp_pos(r_cur_x);
                r_out_y <= clamp_pos(r_cur_y);
                r_cur_x <= r_cur_x + {{(PosWidth-StepWidth){r_step_x[StepWidth-1]}}, r_step_x};
                r_cur_y <= r_cur_y + {{(PosWidth-StepWidth){r_step_y[StepWidth-1]}}, r_step_y};
            end
        end
    end

    // pixel count and end-point flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_remaining   <= '0;
            r_end_pending <= 1'b0;
        end else if (i_cmd.load) begin
            r_remaining   <= length;
            r_end_pending <= 1'b1;
        end else if (i_cmd.emit) begin
            if (r_end_pending) begin
                r_end_pending <= 1'b0;
            end else begin
                r_remaining <= r_remaining - 1'b1;
            end
        end
    end

    assign o_pixel_x     = r_out_x;
    assign o_pixel_y     = r_out_y;
    assign o_pixel_value = r_out_value;
    assign o_last        = r_out_last;

endmodule

// ===== rtl/dda_line_pixel_generator_core.sv =====
// DDA line pixel generator. Each request carries a start and end point in
// unsigned Q5.8 pixel units and a gray level; the block answers with the end
// pixel first, then the pixels from the start point along the line, one per
// cycle while the output side does not stall, with tlast on the final one.
// A request is taken only while the block is idle; the last pixel may still
// sit in the output register when the next request is taken. Per request the
// block accepts it, runs the bit-serial divider that forms the minor-axis
// step, sets up the steps, then emits the pixels (up to 33). Positions
// saturate to 0 .. IMAGE_SIDE-1.
module dda_line_pixel_generator_core
    import dlpg_pkg::*;
#(
    parameter int unsigned IMAGE_SIDE = ImageSideDefault
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_s_tvalid,
    output logic                    o_s_tready,
    // start_x, start_y, end_x, end_y, paint_value, zero pad
    input  logic [InDataWidth-1:0]  i_s_tdata,
    output logic                    o_m_tvalid,
    input  logic                    i_m_tready,
    // pixel_x, pixel_y, pixel_value, zero pad
    output logic [OutDataWidth-1:0] o_m_tdata,
    output logic                    o_m_tlast
);

    t_dp_cmd               cmd;
    t_dp_status            status;
    logic [PixelWidth-1:0] pixel_x;
    logic [PixelWidth-1:0] pixel_y;
    logic [ValueWidth-1:0] pixel_value;

    // sequencer
    dlpg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_m_tready (i_m_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_cmd      (cmd),
        .i_status   (status)
    );

    // divider, stepper and output register
    dlpg_dp #(
        .IMAGE_SIDE (IMAGE_SIDE)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_start_x     (i_s_tdata[12:0]),
        .i_start_y     (i_s_tdata[25:13]),
        .i_end_x       (i_s_tdata[38:26]),
        .i_end_y       (i_s_tdata[51:39]),
        .i_paint_value (i_s_tdata[59:52]),
        .o_pixel_x     (pixel_x),
        .o_pixel_y     (pixel_y),
        .o_pixel_value (pixel_value),
        .o_last        (o_m_tlast)
    );

    // result packing
    assign o_m_tdata = {6'b000000, pixel_value, pixel_y, pixel_x};

endmodule

// ===== test/dda_line_pixel_generator_core_tb.sv =====
`timescale 1ns / 100ps

module dda_line_pixel_generator_core_tb;
    import dlpg_pkg::*;

    localparam int ImageSide    = int'(ImageSideDefault);
    localparam int OneQ16       = 65536;
    localparam int CoordMax     = (1 << CoordWidth) - 1;
    localparam int CycleLimit   = 1000000;
    localparam int TailCycles   = 60;
    localparam int HoldCycles   = 300;
    localparam int InPadWidth   = InDataWidth - 4 * CoordWidth - ValueWidth;

    // one line request
    typedef struct {
        logic [CoordWidth-1:0] start_x;
        logic [CoordWidth-1:0] start_y;
        logic [CoordWidth-1:0] end_x;
        logic [CoordWidth-1:0] end_y;
        logic [ValueWidth-1:0] paint;
    } t_line_req;

    // one pixel to paint
    typedef struct {
        logic [PixelWidth-1:0] x;
        logic [PixelWidth-1:0] y;
        logic [ValueWidth-1:0] value;
        logic                  last;
    } t_pixel;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_s_tvalid = 1'b0;
    logic                    o_s_tready;
    // start_x, start_y, end_x, end_y, paint_value, zero pad
    logic [InDataWidth-1:0]  i_s_tdata = '0;
    logic                    o_m_tvalid;
    logic                    i_m_tready = 1'b0;
    // pixel_x, pixel_y, pixel_value, zero pad
    logic [OutDataWidth-1:0] o_m_tdata;
    logic                    o_m_tlast;

    t_line_req pending_lines[$];
    t_pixel    expected_pixels[$];

    int sender_idle_pct   = 0;
    int receiver_idle_pct = 0;
    int stalls_wanted     = 0;
    int stalls_done       = 0;
    int hold_left         = 0;
    int lines_sent        = 0;
    int pixels_seen       = 0;
    int error_count       = 0;
    int cycle_count       = 0;

    dda_line_pixel_generator_core dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tvalid(i_s_tvalid),
        .o_s_tready(o_s_tready),
        .i_s_tdata (i_s_tdata),
        .o_m_tvalid(o_m_tvalid),
        .i_m_tready(i_m_tready),
        .o_m_tdata (o_m_tdata),
        .o_m_tlast (o_m_tlast)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // floor of a q.16 position, saturated to the image
    function automatic logic [PixelWidth-1:0] to_pixel(input int pos);
        int p;
        if (pos < 0)
            return '0;
        p = pos >>> 16;
        if (p > ImageSide - 1)
            p = ImageSide - 1;
        return p[PixelWidth-1:0];
    endfunction

    // pixels that one line request should produce, end point first
    task automatic predict_line_pixels(input t_line_req r);
        int          dx, dy, pos_x, pos_y, step_x, step_y, count;
        int unsigned adx, ady, quo;
        dx = int'(r.end_x) - int'(r.start_x);
        dy = int'(r.end_y) - int'(r.start_y);
        adx = (dx < 0) ? -dx : dx;
        ady = (dy < 0) ? -dy : dy;
        pos_x = int'(r.start_x) * 256;
        pos_y = int'(r.start_y) * 256;
        if (dx == 0) begin
            step_x = 0;
            step_y = (dy > 0) ? OneQ16 : -OneQ16;
            count = ady >> 8;
        end else if (ady > adx) begin
            step_y = (dy > 0) ? OneQ16 : -OneQ16;
            quo = (adx << 16) / ady;
            step_x = (dx < 0) ? -int'(quo) : int'(quo);
            count = (ady >> 8) + 1;
        end else begin
            step_x = (dx > 0) ? OneQ16 : -OneQ16;
            quo = (ady << 16) / adx;
            step_y = (dy < 0) ? -int'(quo) : int'(quo);
            count = (adx >> 8) + 1;
        end
        count = count & 63;
        expected_pixels.push_back('{to_pixel(int'(r.end_x) * 256),
            to_pixel(int'(r.end_y) * 256), r.paint, count == 0});
        while (count != 0) begin
            count--;
            expected_pixels.push_back('{to_pixel(pos_x), to_pixel(pos_y), r.paint,
                count == 0});
            pos_x += step_x;
            pos_y += step_y;
        end
    endtask

    // sender: holds a request until taken, otherwise offers the next one or idles
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else begin
            if (i_s_tvalid && o_s_tready) begin
                predict_line_pixels(pending_lines.pop_front());
                lines_sent++;
            end
            if (!(i_s_tvalid && !o_s_tready)) begin
                if (pending_lines.size() != 0 &&
                        $urandom_range(99) >= sender_idle_pct) begin
                    i_s_tvalid <= 1'b1;
                    i_s_tdata  <= {{InPadWidth{1'b0}}, pending_lines[0].paint,
                                   pending_lines[0].end_y, pending_lines[0].end_x,
                                   pending_lines[0].start_y, pending_lines[0].start_x};
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver: random back-pressure plus long hold-offs on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left = hold_left - 1;
            i_m_tready <= 1'b0;
        end else if (stalls_done != stalls_wanted) begin
            hold_left = HoldCycles;
            stalls_done = stalls_done + 1;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= ($urandom_range(99) >= receiver_idle_pct);
        end
    end

    // compare each taken pixel with the oldest expected one
    always @(posedge i_clk) begin
        t_pixel want, got;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = '{o_m_tdata[PixelWidth-1:0], o_m_tdata[2*PixelWidth-1:PixelWidth],
                    o_m_tdata[2*PixelWidth+ValueWidth-1:2*PixelWidth], o_m_tlast};
            pixels_seen++;
            if (expected_pixels.size() == 0) begin
                error_count++;
                $display("%0t: expected no pixel, got (%0d,%0d) %0d %0d",
                    $time, got.x, got.y, got.value, got.last);
            end else begin
                want = expected_pixels.pop_front();
                if (got.x !== want.x || got.y !== want.y ||
                        got.value !== want.value || got.last !== want.last) begin
                    error_count++;
                    $display("%0t: expected (%0d,%0d) %0d %0d, got (%0d,%0d) %0d %0d",
                        $time, want.x, want.y, want.value, want.last,
                        got.x, got.y, got.value, got.last);
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CycleLimit) begin
            $display("timeout after %0d cycles, %0d pixels still expected",
                cycle_count, expected_pixels.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic add_line(input int sx, input int sy, input int ex, input int ey,
                            input int paint);
        pending_lines.push_back('{sx[CoordWidth-1:0], sy[CoordWidth-1:0],
            ex[CoordWidth-1:0], ey[CoordWidth-1:0], paint[ValueWidth-1:0]});
    endtask

    // coordinate within span of base, kept inside the coordinate range
    function automatic int near(input int base, input int span);
        int c;
        c = base + int'($urandom_range(2 * span)) - span;
        if (c < 0)
            c = 0;
        if (c > CoordMax)
            c = CoordMax;
        return c;
    endfunction

    // mostly shaped lines with random content, some fully random
    task automatic add_random_lines(input int n);
        int sx, sy, ex, ey, d, room_x, room_y, sel;
        repeat (n) begin
            sx = $urandom_range(CoordMax);
            sy = $urandom_range(CoordMax);
            ex = $urandom_range(CoordMax);
            ey = $urandom_range(CoordMax);
            sel = $urandom_range(99);
            if (sel < 35) begin
                // fully random end points
            end else if (sel < 55) begin
                ex = near(sx, 1024);
                ey = near(sy, 1024);
            end else if (sel < 70) begin
                ex = sx;
            end else if (sel < 80) begin
                ey = sy;
            end else if (sel < 90) begin
                // diagonal tie in a random direction
                room_x = $urandom_range(1) ? CoordMax - sx : -sx;
                room_y = $urandom_range(1) ? CoordMax - sy : -sy;
                d = (room_x < 0 ? -room_x : room_x);
                if ((room_y < 0 ? -room_y : room_y) < d)
                    d = (room_y < 0 ? -room_y : room_y);
                d = $urandom_range(d);
                ex = sx + (room_x < 0 ? -d : d);
                ey = sy + (room_y < 0 ? -d : d);
            end else begin
                // vertical line shorter than one row
                ex = sx;
                ey = near(sy, 255);
            end
            add_line(sx, sy, ex, ey, $urandom_range(255));
        end
    endtask

    task automatic wait_drained();
        while (pending_lines.size() != 0 || expected_pixels.size() != 0)
            @(posedge i_clk);
    endtask

    initial begin
        sender_idle_pct   = 34;
        receiver_idle_pct = 73;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // zero-length vertical lines at both extremes
        add_line(0, 0, 0, 0, 0);
        add_line(CoordMax, CoordMax, CoordMax, CoordMax, 255);
        // diagonal ties
        add_line(0, 0, CoordMax, CoordMax, 'hA5);
        add_line(CoordMax, CoordMax, 0, 0, 'h5A);
        add_line(0, CoordMax, CoordMax, 0, 'h0F);
        // horizontal
        add_line(0, 0, CoordMax, 0, 'hF0);
        add_line(CoordMax, 100, 0, 100, 1);
        // vertical, full span both ways, then just under and at one row
        add_line(1000, 0, 1000, CoordMax, 2);
        add_line(1000, CoordMax, 1000, 0, 4);
        add_line(500, 500, 500, 755, 8);
        add_line(500, 500, 500, 756, 16);
        // one-unit moves along x
        add_line(0, 0, 1, 0, 32);
        add_line(1, 0, 0, 0, 64);
        add_line(128, 7000, 129, 7000, 128);
        // steep with tiny minor span
        add_line(0, 0, 1, CoordMax, 254);
        add_line(CoordMax, 0, CoordMax - 1, CoordMax, 253);
        // just off the diagonal on either side, then a one-row horizontal and a diagonal
        add_line(0, 0, CoordMax, CoordMax - 1, 'h33);
        add_line(0, 0, CoordMax - 1, CoordMax, 'hCC);
        add_line(4096, 4096, 4352, 4096, 'h77);
        add_line(255, 255, CoordMax, CoordMax, 'h88);
        // alternating bit patterns, then the full anti-diagonal
        add_line('h1555, 'h0AAA, 'h0AAA, 'h1555, 'h55);
        add_line('h0AAA, 'h1555, 'h1555, 'h0AAA, 'hAA);
        add_line(CoordMax, 0, 0, CoordMax, 'hFF);
        add_random_lines(140);
        wait_drained();

        // swap the pacing of the two sides
        @(negedge i_clk);
        sender_idle_pct   <= 73;
        receiver_idle_pct <= 34;
        add_random_lines(150);
        wait_drained();

        // full rate, with one long output hold-off while requests queue up
        @(negedge i_clk);
        sender_idle_pct   <= 0;
        receiver_idle_pct <= 0;
        add_random_lines(150);
        stalls_wanted <= 1;
        wait_drained();

        repeat (TailCycles) @(posedge i_clk);
        $display("%0d line requests sent, %0d pixels checked over three pacing phases",
            lines_sent, pixels_seen);
        $display("and a %0d-cycle output hold-off, %0d mismatches", HoldCycles, error_count);
        if (error_count == 0 && expected_pixels.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ===== dda_line_pixel_generator_core.f =====
rtl/dlpg_pkg.sv
rtl/dlpg_ctrl.sv
rtl/dlpg_dp.sv
rtl/dda_line_pixel_generator_core.sv
test/dda_line_pixel_generator_core_tb.sv
